### sv/assert_macros.svh
// Assertion helpers included by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

### sv/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

  // Default number of cache slots, and an unused limit.
  localparam int unsigned CpcDefaultSlots = 16;
  localparam int unsigned CpcMaxSlots     = 120;

  // Reset value of the active entries register.
  localparam logic [4:0] CpcActiveReset = 5'd16;

  // Command codes of an input transaction.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_MISS   = 4'b0100,
    ST_RESP   = 4'b1000
  } cpc_state_e;

endpackage

`default_nettype wire

### sv/cpc_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module cpc_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/color_pair_cache_round_robin.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  command_i, background_color_i,
//                                               foreground_color_i
// output    out        out_valid_o / out_stall_i slot_index_o, hit_o
// config    in         cfg_we_i                 cfg_wdata_i (active entries)
//
// A lookup reads the single read port of the pair table once per filled slot,
// from the slot reported last, and compares the registered read data with the
// key; a hit ends the search, while a miss or an empty table writes the pair
// into a slot. A clear skips the search. The result then goes to the output
// register, and the next transaction can be accepted in the cycle after that.
// Reset empties the table logically (count zero); the table memory itself is
// never cleared, since only filled slots are read.
// A stalled output only holds the finished result; the next transaction is
// accepted while it waits, and the sequencer stalls only when a second result
// is ready and the output register is still occupied.

module color_pair_cache_round_robin
  import cpc_pkg::*;
#(
  parameter int unsigned SLOTS = CpcDefaultSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [23:0] background_color_i,
  input  wire logic [23:0] foreground_color_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       slot_index_o,
  output logic             hit_o,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  `include "assert_macros.svh"

  // Index width of a slot, width of a count of slots, and a width that
  // holds an index plus one.
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = IW + 1;
  localparam logic [7:0] SlotsConst = 8'(SLOTS);

  cpc_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] rp_q, rp_d;
  logic [IW-1:0] lh_q, lh_d;
  logic [4:0]    act_q;

  logic [47:0]   key_q, key_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          cmp_last_q, cmp_last_d;
  logic [IW-1:0] cmp_slot_q, cmp_slot_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  logic          res_hit_q, res_hit_d;

  logic          out_vld_q, out_vld_d;
  logic [3:0]    out_slot_q, out_slot_d;
  logic          out_hit_q, out_hit_d;

  logic          in_acc;
  logic          out_free;
  logic          issue;
  logic          match;
  logic [PW-1:0] ptr_inc;
  logic [IW-1:0] ptr_wrap;
  logic [PW-1:0] rp_inc;
  logic [IW-1:0] rp_wrap;
  logic [7:0]    act_ext;
  logic [7:0]    eff_size;
  logic          room;
  logic [IW-1:0] new_rp;
  logic [IW+3:0] res_slot_ext;

  logic          ram_we;
  logic [47:0]   ram_rdata;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && (state_q == ST_IDLE);
  assign out_free     = !out_vld_q || !out_stall_i;
  assign out_valid_o  = out_vld_q;
  assign slot_index_o = out_slot_q;
  assign hit_o        = out_hit_q;

  // The search walks the filled slots, wrapping at the fill count.
  assign issue    = (state_q == ST_SEARCH) && (iss_q < cnt_q);
  assign ptr_inc  = PW'(ptr_q) + PW'(1);
  assign ptr_wrap = (ptr_inc == PW'(cnt_q)) ? '0 : ptr_inc[IW-1:0];
  assign match    = cmp_vld_q && (ram_rdata == key_q);

  // Effective table size: zero counts as one, and it never exceeds the
  // number of physical slots.
  assign act_ext  = 8'(act_q);
  always_comb begin
    if (act_ext == 8'd0) begin
      eff_size = 8'd1;
    end else if (act_ext > SlotsConst) begin
      eff_size = SlotsConst;
    end else begin
      eff_size = act_ext;
    end
  end

  // Replacement: fill the next free slot while there is room, otherwise
  // advance round-robin over all filled slots.
  assign room    = (8'(cnt_q) < eff_size);
  assign rp_inc  = PW'(rp_q) + PW'(1);
  assign rp_wrap = (rp_inc >= PW'(cnt_q)) ? '0 : rp_inc[IW-1:0];
  assign new_rp  = room ? IW'(cnt_q) : rp_wrap;
  assign ram_we  = (state_q == ST_MISS);

  assign res_slot_ext = {4'b0000, res_slot_q};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rp_d       = rp_q;
    lh_d       = lh_q;
    key_d      = key_q;
    ptr_d      = ptr_q;
    iss_d      = iss_q;
    cmp_vld_d  = issue;
    cmp_last_d = cmp_last_q;
    cmp_slot_d = cmp_slot_q;
    res_slot_d = res_slot_q;
    res_hit_d  = res_hit_q;
    out_vld_d  = out_vld_q;
    out_slot_d = out_slot_q;
    out_hit_d  = out_hit_q;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (issue) begin
      ptr_d      = ptr_wrap;
      iss_d      = iss_q + CW'(1);
      cmp_slot_d = ptr_q;
      cmp_last_d = ((iss_q + CW'(1)) == cnt_q);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (command_i == CMD_CLEAR) begin
            cnt_d      = '0;
            rp_d       = '0;
            lh_d       = '0;
            res_slot_d = '0;
            res_hit_d  = 1'b0;
            state_d    = ST_RESP;
          end else begin
            key_d   = {background_color_i, foreground_color_i};
            ptr_d   = (CW'(lh_q) < cnt_q) ? lh_q : '0;
            iss_d   = '0;
            state_d = (cnt_q == '0) ? ST_MISS : ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          res_slot_d = cmp_slot_q;
          res_hit_d  = 1'b1;
          lh_d       = cmp_slot_q;
          state_d    = ST_RESP;
        end else if (cmp_vld_q && cmp_last_q) begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        rp_d = new_rp;
        if (room) begin
          cnt_d = cnt_q + CW'(1);
        end
        res_slot_d = new_rp;
        res_hit_d  = 1'b0;
        lh_d       = new_rp;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_slot_d = res_slot_ext[3:0];
          out_hit_d  = res_hit_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rp_q      <= '0;
      lh_q      <= '0;
      act_q     <= CpcActiveReset;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rp_q      <= rp_d;
      lh_q      <= lh_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    ptr_q      <= ptr_d;
    iss_q      <= iss_d;
    cmp_last_q <= cmp_last_d;
    cmp_slot_q <= cmp_slot_d;
    res_slot_q <= res_slot_d;
    res_hit_q  <= res_hit_d;
    out_slot_q <= out_slot_d;
    out_hit_q  <= out_hit_d;
  end

  cpc_ram #(
    .Width (48),
    .Depth (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (new_rp),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // The replace and last-hit pointers name a filled slot while any is filled.
  `ASSERT_AT(a_rp_in_range, clk_i, rst_ni, (cnt_q == '0) || (CW'(rp_q) < cnt_q))
  `ASSERT_AT(a_lh_in_range, clk_i, rst_ni, (lh_q == '0) || (CW'(lh_q) < cnt_q))
  // An accepted transaction always starts the sequencer.
  `ASSERT_AT(a_accept_busy, clk_i, rst_ni, in_acc |=> (state_q != ST_IDLE))
  // A fill always leaves at least one filled slot behind.
  `ASSERT_AT(a_miss_fills, clk_i, rst_ni, (state_q == ST_MISS) |=> (cnt_q != '0))
  // No compare is pending once the sequencer is back in idle.
  `ASSERT_NEVER(a_no_stale_cmp, clk_i, rst_ni, cmp_vld_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

### dv/color_pair_cache_round_robin_test.sv
`timescale 1ns / 1ps

// The cache is exercised through its input and output channels. Every accepted
// transaction is run through a local copy of the cache behavior, and the
// resulting slot and hit flag are queued. Results leaving the block are
// checked in order against that queue. The active entries register is
// reprogrammed between phases, only once the block has drained.

module color_pair_cache_round_robin_test;
  import cpc_pkg::*;

  // Cycles allowed for the block to finish a lookup and settle its table
  // after the last expected result, before the register may change.
  localparam int SettleCycles = CpcDefaultSlots + 8;
  // Hard stop for the whole run.
  localparam int CycleLimit = 1000000;
  // Random part: eight register settings, about 180 transactions each.
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 178;
  // Chance, in percent, that either side idles in a given cycle.
  localparam int IdlePercent = 26;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [3:0] slot;
    logic       hit;
  } cache_answer_t;

  // The scoreboard keeps its own copy of the cache state and turns every
  // accepted transaction into the answer that the block must give.
  class pair_cache_scoreboard;
    logic [47:0]   pair_store[CpcDefaultSlots];
    int unsigned   filled;
    int unsigned   victim;
    int unsigned   recent;
    logic [4:0]    active_setting;
    cache_answer_t awaited[$];
    int unsigned   faults;

    function new();
      foreach (pair_store[i]) pair_store[i] = '0;
      filled = 0;
      victim = 0;
      recent = 0;
      active_setting = CpcActiveReset;
      faults = 0;
    endfunction

    function void set_active(logic [4:0] value);
      active_setting = value;
    endfunction

    function int unsigned usable_slots();
      int unsigned n;
      n = 32'(active_setting);
      if (n < 1) n = 1;
      if (n > CpcDefaultSlots) n = CpcDefaultSlots;
      return n;
    endfunction

    function void absorb_request(logic cmd, logic [23:0] bg, logic [23:0] fg);
      logic [47:0]   key;
      cache_answer_t answer;
      int unsigned   start;
      int unsigned   s;
      bit            found;
      key = {bg, fg};
      answer = '0;
      found = 1'b0;
      if (cmd == CMD_CLEAR) begin
        foreach (pair_store[i]) pair_store[i] = '0;
        filled = 0;
        victim = 0;
        recent = 0;
        awaited.push_back(answer);
        return;
      end
      // The search begins at the slot reported last and wraps around.
      start = (recent < filled) ? recent : 0;
      for (int unsigned k = 0; k < filled && !found; k++) begin
        s = start + k;
        if (s >= filled) s -= filled;
        if (pair_store[s] == key) begin
          answer.slot = s[3:0];
          found = 1'b1;
        end
      end
      if (found) begin
        answer.hit = 1'b1;
      end else begin
        // Fill free slots first, then cycle over every filled slot, even when
        // the register has since been lowered below the fill level.
        if (filled < usable_slots()) begin
          victim = filled;
          filled++;
        end else begin
          victim++;
          if (victim >= filled) victim = 0;
        end
        pair_store[victim % CpcDefaultSlots] = key;
        answer.slot = victim[3:0];
      end
      recent = 32'(answer.slot);
      awaited.push_back(answer);
    endfunction

    function void flag(string what);
      faults++;
      if (faults <= ReportLimit) $display("[%0t] ERROR: %s", $time, what);
    endfunction

    function void check_result(logic [3:0] slot, logic hit);
      cache_answer_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result slot=%0d hit=%0b arrived with nothing outstanding",
                       slot, hit));
        return;
      end
      want = awaited.pop_front();
      if (slot !== want.slot)
        flag($sformatf("slot_index expected %0d, got %0d", want.slot, slot));
      if (hit !== want.hit)
        flag($sformatf("hit expected %0b, got %0b", want.hit, hit));
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void flag_leftovers();
      while (awaited.size() > 0) begin
        cache_answer_t want;
        want = awaited.pop_front();
        flag($sformatf("no result for expected slot=%0d hit=%0b", want.slot,
                       want.hit));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [23:0] background_color_i;
  logic [23:0] foreground_color_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  slot_index_o;
  logic        hit_o;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;

  pair_cache_scoreboard ledger;
  // While steady is set, neither side inserts idle cycles.
  bit          steady;
  int unsigned tick_count;

  color_pair_cache_round_robin dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .background_color_i (background_color_i),
    .foreground_color_i (foreground_color_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .slot_index_o       (slot_index_o),
    .hit_o              (hit_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IdlePercent);
  endfunction

  // The output side stalls at random. Signals are sampled right after the
  // rising edge, so every check sees the values that the edge itself saw.
  always @(posedge clk_i) begin
    out_stall_i <= take_break();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) ledger.check_result(slot_index_o, hit_o);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    tick_count++;
    if (tick_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one transaction, possibly after some idle cycles, and returns in
  // the time step of the edge that accepted it. Valid stays high on return so
  // that a following transaction can go out back to back.
  task automatic push_transaction(input logic cmd, input logic [23:0] bg,
                                  input logic [23:0] fg);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    background_color_i <= bg;
    foreground_color_i <= fg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.absorb_request(cmd, bg, fg);
  endtask

  // Lowers valid and waits until every queued answer has come back, plus a
  // margin so that a table write still in flight can complete.
  task automatic drain_cache();
    in_valid_i <= 1'b0;
    while (ledger.outstanding() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_active(input logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_active(value);
  endtask

  // Opening sequence at the reset setting of sixteen slots: the extreme
  // colors, hits and misses, a clear carrying nonzero colors, a fill of the
  // whole table and the first round-robin replacement.
  task automatic run_directed();
    logic [23:0] tint;
    push_transaction(CMD_LOOKUP, 24'h000000, 24'h000000);
    push_transaction(CMD_LOOKUP, 24'h000000, 24'h000000);
    push_transaction(CMD_LOOKUP, 24'hFFFFFF, 24'hFFFFFF);
    push_transaction(CMD_LOOKUP, 24'hFFFFFF, 24'h000000);
    push_transaction(CMD_LOOKUP, 24'h000000, 24'hFFFFFF);
    push_transaction(CMD_LOOKUP, 24'hFFFFFF, 24'hFFFFFF);
    push_transaction(CMD_CLEAR, 24'hAAAAAA, 24'h555555);
    // The clear emptied the table, so even an all-zero pair must miss.
    push_transaction(CMD_LOOKUP, 24'h000000, 24'h000000);
    for (int i = 1; i < CpcDefaultSlots; i++) begin
      tint = 24'(24'h010203 * i);
      push_transaction(CMD_LOOKUP, tint, ~tint);
    end
    // Table is full: this one wraps the replacement back to slot zero.
    push_transaction(CMD_LOOKUP, 24'h123456, 24'h654321);
    push_transaction(CMD_LOOKUP, 24'h123456, 24'h654321);
  endtask

  // One random phase under a single register setting. Most lookups draw from
  // a small pool of pairs so that hits, misses and replacements all occur;
  // a few bring fresh pairs and a few clear the cache.
  task automatic run_phase(input logic [4:0] setting, input int count);
    logic [47:0] pool[24];
    int          pool_size;
    int          pick;
    int          roll;
    logic [47:0] pair;
    pool_size = $urandom_range(2, 24);
    foreach (pool[i]) pool[i] = 48'({$urandom(), $urandom()});
    program_active(setting);
    if ($urandom_range(0, 1) == 1)
      push_transaction(CMD_CLEAR, 24'($urandom()), 24'($urandom()));
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, pool_size - 1);
      if (roll < 3) begin
        push_transaction(CMD_CLEAR, 24'($urandom()), 24'($urandom()));
      end else begin
        if (roll < 15) pool[pick] = 48'({$urandom(), $urandom()});
        pair = pool[pick];
        push_transaction(CMD_LOOKUP, pair[47:24], pair[23:0]);
      end
    end
    drain_cache();
  endtask

  initial begin
    logic [4:0] phase_setting[PhaseCount];
    ledger             = new();
    steady             = 1'b0;
    tick_count         = 0;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    command_i          <= CMD_LOOKUP;
    background_color_i <= '0;
    foreground_color_i <= '0;
    out_stall_i        <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    // The first setting lowers the register while all sixteen slots are still
    // filled. Zero must act as one and values above sixteen as sixteen.
    phase_setting = '{5'd4, 5'd0, 5'd1, 5'd31, 5'd16, 5'd17, 5'd9, 5'd2};
    phase_setting[PhaseCount - 1] = 5'($urandom_range(0, 31));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain_cache();
    for (int p = 0; p < PhaseCount; p++) begin
      // One phase runs with no idle cycles on either side.
      steady = (p == 4);
      run_phase(phase_setting[p], PhaseItems);
    end

    ledger.flag_leftovers();
    if (ledger.faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
